>>> rtl/core/ptrk_pkg.sv
// ----------------------------------------------------------------------------
// ptrk_pkg
// Shared types, constants and helpers of the people crossing tracker.
// ----------------------------------------------------------------------------
package ptrk_pkg;

    localparam int MAX_OBJECTS_DEF = 16;

    localparam logic signed [15:0] LINE_Y_RST    = 16'sd102;
    localparam logic [14:0]        MIN_TRAVEL_RST = 15'd614;
    localparam logic [14:0]        MOVED_THR_RST  = 15'd102;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DETECT = 2'd1;
    localparam logic [1:0] OP_AUDIT  = 2'd2;

    localparam logic [1:0] REG_LINE_Y     = 2'd0;
    localparam logic [1:0] REG_MIN_TRAVEL = 2'd1;
    localparam logic [1:0] REG_MOVED_THR  = 2'd2;

    typedef struct packed {
        logic [15:0]        ident;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] box_max_y;
        logic signed [15:0] box_min_y;
        logic signed [15:0] box_max_x;
        logic signed [15:0] box_min_x;
        logic [31:0]        movement_sq;
    } entry_t;

    function automatic logic signed [21:0] times10(input logic signed [15:0] v);
        logic signed [21:0] e;
        e = 22'(v);
        return (e <<< 3) + (e <<< 1);
    endfunction

endpackage

>>> rtl/core/people_crossing_tracker.sv
// ----------------------------------------------------------------------------
// people_crossing_tracker
// Box tracker with ordered entry table and line crossing counters.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                               tuser
// s_       in   center_x, center_y, box_min_x, box_max_x,        operation
//               box_min_y, box_max_y
// m_       out  object_id, count_in, count_out, live_objects     is_new, dropped
// cfg_     in   cfg_index selects register, cfg_data is the value
//
// Start frame clears the tracked flags. Detection scans every live entry,
// squares the distance of each unmatched overlapping entry, then appends or
// drops, or updates the winner. Audit squares the travel threshold and scans
// all live entries. Both share the squarer and the single table read port.
// Reset is synchronous; no table clear is needed. A stalled result holds the
// block before it is loaded.
module people_crossing_tracker #(
    parameter int MAX_OBJECTS = ptrk_pkg::MAX_OBJECTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // center_x, center_y, box_min_x, box_max_x, box_min_y, box_max_y
    input  logic [1:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // object_id, count_in, count_out, live_objects, zero fill
    output logic [1:0]   m_tuser,   // is_new, dropped
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    localparam int IW = $clog2(MAX_OBJECTS);
    localparam int CW = $clog2(MAX_OBJECTS + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_DT   = 4'd2;
    localparam logic [3:0] ST_SQX  = 4'd3;
    localparam logic [3:0] ST_SQY  = 4'd4;
    localparam logic [3:0] ST_RES  = 4'd5;
    localparam logic [3:0] ST_WR   = 4'd6;
    localparam logic [3:0] ST_WS1  = 4'd7;
    localparam logic [3:0] ST_WS2  = 4'd8;
    localparam logic [3:0] ST_WS3  = 4'd9;
    localparam logic [3:0] ST_AS   = 4'd10;
    localparam logic [3:0] ST_AN   = 4'd11;
    localparam logic [3:0] ST_ARD  = 4'd12;
    localparam logic [3:0] ST_ADT  = 4'd13;
    localparam logic [3:0] ST_FIN  = 4'd14;

    logic [3:0] state_reg;

    logic signed [15:0] line_y_reg;
    logic [14:0]        min_travel_reg;
    logic [14:0]        moved_thr_reg;

    logic signed [15:0] cx_reg, cy_reg, bminx_reg, bmaxx_reg, bminy_reg, bmaxy_reg;

    logic [MAX_OBJECTS-1:0] tracked_reg;
    logic [MAX_OBJECTS-1:0] moved_reg;
    logic [CW-1:0]      live_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      kept_reg;
    logic [15:0]        next_id_reg;
    logic [15:0]        total_in_reg, total_out_reg;

    logic               near_found_reg;
    logic [IW-1:0]      near_idx_reg;
    logic [33:0]        near_d_reg;
    logic               best_found_reg;
    logic [IW-1:0]      best_idx_reg;
    logic [31:0]        best_mv_reg;
    logic [IW-1:0]      one_idx_reg;
    logic [1:0]         moved_n_reg;
    logic [IW-1:0]      win_reg;
    logic [32:0]        acc_reg;
    logic [31:0]        mvn_reg;
    logic [32:0]        need_reg;

    logic [15:0]        id_reg;
    logic               new_reg, drop_reg;

    logic [15:0]        m_id_reg, m_in_reg, m_out_reg;
    logic [4:0]         m_live_reg;
    logic               m_new_reg, m_drop_reg, m_valid_reg;

    logic               ram_we, ram_re;
    logic [IW-1:0]      ram_waddr, ram_raddr;
    ptrk_pkg::entry_t   ram_wdata, ent;
    logic signed [16:0] sq_in;
    logic [32:0]        sq_out;

    ptrk_ram #(.DEPTH(MAX_OBJECTS)) u_ram (
        .aclk      (aclk),
        .we        (ram_we),
        .waddr     (ram_waddr),
        .wdata     (ram_wdata),
        .re        (ram_re),
        .raddr     (ram_raddr),
        .rdata_reg (ent)
    );

    ptrk_sq u_sq (
        .aclk       (aclk),
        .operand    (sq_in),
        .square_reg (sq_out)
    );

    logic [IW-1:0]      idx;
    logic signed [16:0] ddx, ddy, tdx, tdy, m_ext, n_ext;
    logic signed [21:0] l1, l2, l3, l4;
    logic               overlap, last_entry, out_free;
    logic [33:0]        dsum;
    logic [33:0]        mv_full;
    logic [31:0]        mv_sat;

    assign idx        = idx_reg[IW-1:0];
    assign last_entry = (idx_reg + CW'(1)) == live_reg;
    assign out_free   = !m_valid_reg || m_tready;

    always_comb begin
        ddx   = 17'(bmaxx_reg) - 17'(bminx_reg);
        ddy   = 17'(bmaxy_reg) - 17'(bminy_reg);
        tdx   = 17'(ent.box_max_x) - 17'(ent.box_min_x);
        tdy   = 17'(ent.box_max_y) - 17'(ent.box_min_y);
        m_ext = (ddx < tdx) ? ddx : tdx;
        n_ext = (ddy < tdy) ? ddy : tdy;
        l1 = ptrk_pkg::times10(ent.box_min_x) + 22'(m_ext);
        l2 = ptrk_pkg::times10(ent.box_max_x) - 22'(m_ext);
        l3 = ptrk_pkg::times10(ent.box_max_y) - 22'(n_ext);
        l4 = ptrk_pkg::times10(ent.box_min_y) + 22'(n_ext);
        overlap = !(l1 > ptrk_pkg::times10(bmaxx_reg) || l2 < ptrk_pkg::times10(bminx_reg) ||
                    l3 < ptrk_pkg::times10(bminy_reg) || l4 > ptrk_pkg::times10(bmaxy_reg));
        dsum    = {1'b0, acc_reg} + {1'b0, sq_out};
        mv_full = dsum;
        mv_sat  = (mv_full[33:32] != 2'b00) ? 32'hFFFF_FFFF : mv_full[31:0];
    end

    always_comb begin
        sq_in = '0;
        case (state_reg)
            ST_DT:   sq_in = 17'(ent.center_x) - 17'(cx_reg);
            ST_SQX:  sq_in = 17'(ent.center_y) - 17'(cy_reg);
            ST_WR:   sq_in = 17'(ent.origin_x) - 17'(cx_reg);
            ST_WS1:  sq_in = 17'(ent.origin_y) - 17'(cy_reg);
            ST_WS2:  sq_in = 17'({2'b00, moved_thr_reg});
            ST_AS:   sq_in = 17'({2'b00, min_travel_reg});
            default: sq_in = '0;
        endcase
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = idx;
        ram_we    = 1'b0;
        ram_waddr = idx;
        ram_wdata = ent;
        case (state_reg)
            ST_RD, ST_ARD: begin
                ram_re = 1'b1;
            end
            ST_RES: begin
                ram_re    = near_found_reg;
                ram_raddr = (moved_n_reg == 2'd1) ? one_idx_reg :
                            best_found_reg ? best_idx_reg : near_idx_reg;
                ram_we    = !near_found_reg && (live_reg < CW'(MAX_OBJECTS));
                ram_waddr = live_reg[IW-1:0];
                ram_wdata.ident       = next_id_reg;
                ram_wdata.center_x    = cx_reg;
                ram_wdata.center_y    = cy_reg;
                ram_wdata.origin_x    = cx_reg;
                ram_wdata.origin_y    = cy_reg;
                ram_wdata.box_min_x   = bminx_reg;
                ram_wdata.box_max_x   = bmaxx_reg;
                ram_wdata.box_min_y   = bminy_reg;
                ram_wdata.box_max_y   = bmaxy_reg;
                ram_wdata.movement_sq = '0;
            end
            ST_WS3: begin
                ram_we    = 1'b1;
                ram_waddr = win_reg;
                ram_wdata.center_x    = cx_reg;
                ram_wdata.center_y    = cy_reg;
                ram_wdata.box_min_x   = bminx_reg;
                ram_wdata.box_max_x   = bmaxx_reg;
                ram_wdata.box_min_y   = bminy_reg;
                ram_wdata.box_max_y   = bmaxy_reg;
                ram_wdata.movement_sq = mvn_reg;
            end
            ST_ADT: begin
                ram_we    = tracked_reg[idx];
                ram_waddr = kept_reg[IW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_y_reg     <= ptrk_pkg::LINE_Y_RST;
            min_travel_reg <= ptrk_pkg::MIN_TRAVEL_RST;
            moved_thr_reg  <= ptrk_pkg::MOVED_THR_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                ptrk_pkg::REG_LINE_Y:     line_y_reg     <= cfg_data;
                ptrk_pkg::REG_MIN_TRAVEL: min_travel_reg <= cfg_data[14:0];
                ptrk_pkg::REG_MOVED_THR:  moved_thr_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tracked_reg   <= '0;
            moved_reg     <= '0;
            live_reg      <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            next_id_reg   <= '0;
            total_in_reg  <= '0;
            total_out_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cx_reg    <= s_tdata[15:0];
                        cy_reg    <= s_tdata[31:16];
                        bminx_reg <= s_tdata[47:32];
                        bmaxx_reg <= s_tdata[63:48];
                        bminy_reg <= s_tdata[79:64];
                        bmaxy_reg <= s_tdata[95:80];
                        id_reg    <= '0;
                        new_reg   <= 1'b0;
                        drop_reg  <= 1'b0;
                        idx_reg   <= '0;
                        kept_reg  <= '0;
                        near_found_reg <= 1'b0;
                        best_found_reg <= 1'b0;
                        best_mv_reg    <= '0;
                        moved_n_reg    <= '0;
                        case (s_tuser)
                            ptrk_pkg::OP_START: begin
                                tracked_reg <= '0;
                                state_reg   <= ST_FIN;
                            end
                            ptrk_pkg::OP_DETECT: begin
                                state_reg <= (live_reg == '0) ? ST_RES : ST_RD;
                            end
                            ptrk_pkg::OP_AUDIT: begin
                                state_reg <= ST_AS;
                            end
                            default: state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_RD: state_reg <= ST_DT;
                ST_DT: begin
                    if (!tracked_reg[idx] && overlap) begin
                        state_reg <= ST_SQX;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= last_entry ? ST_RES : ST_RD;
                    end
                end
                ST_SQX: begin
                    acc_reg   <= sq_out;
                    state_reg <= ST_SQY;
                end
                ST_SQY: begin
                    if (!near_found_reg || dsum < near_d_reg) begin
                        near_found_reg <= 1'b1;
                        near_d_reg     <= dsum;
                        near_idx_reg   <= idx;
                    end
                    if (moved_reg[idx]) begin
                        if (moved_n_reg != 2'd2) begin
                            moved_n_reg <= moved_n_reg + 2'd1;
                        end
                        one_idx_reg <= idx;
                        if (ent.movement_sq > best_mv_reg) begin
                            best_mv_reg    <= ent.movement_sq;
                            best_idx_reg   <= idx;
                            best_found_reg <= 1'b1;
                        end
                    end
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= last_entry ? ST_RES : ST_RD;
                end
                ST_RES: begin
                    if (near_found_reg) begin
                        win_reg   <= ram_raddr;
                        state_reg <= ST_WR;
                    end else if (live_reg < CW'(MAX_OBJECTS)) begin
                        tracked_reg[live_reg[IW-1:0]] <= 1'b1;
                        moved_reg[live_reg[IW-1:0]]   <= 1'b0;
                        id_reg      <= next_id_reg;
                        new_reg     <= 1'b1;
                        live_reg    <= live_reg + CW'(1);
                        next_id_reg <= next_id_reg + 16'd1;
                        state_reg   <= ST_FIN;
                    end else begin
                        drop_reg  <= 1'b1;
                        state_reg <= ST_FIN;
                    end
                end
                ST_WR: state_reg <= ST_WS1;
                ST_WS1: begin
                    acc_reg   <= sq_out;
                    state_reg <= ST_WS2;
                end
                ST_WS2: begin
                    mvn_reg   <= (mv_sat > ent.movement_sq) ? mv_sat : ent.movement_sq;
                    state_reg <= ST_WS3;
                end
                ST_WS3: begin
                    tracked_reg[win_reg] <= 1'b1;
                    if ({1'b0, mvn_reg} >= sq_out) begin
                        moved_reg[win_reg] <= 1'b1;
                    end
                    id_reg    <= ent.ident;
                    state_reg <= ST_FIN;
                end
                ST_AS: state_reg <= ST_AN;
                ST_AN: begin
                    need_reg  <= sq_out;
                    state_reg <= (live_reg == '0) ? ST_FIN : ST_ARD;
                end
                ST_ARD: state_reg <= ST_ADT;
                ST_ADT: begin
                    if (tracked_reg[idx]) begin
                        tracked_reg[kept_reg[IW-1:0]] <= 1'b1;
                        moved_reg[kept_reg[IW-1:0]]   <= moved_reg[idx];
                        kept_reg <= kept_reg + CW'(1);
                    end else if ({1'b0, ent.movement_sq} > need_reg) begin
                        if (ent.origin_y > line_y_reg && ent.center_y < line_y_reg) begin
                            total_in_reg <= total_in_reg + 16'd1;
                        end else if (ent.origin_y < line_y_reg &&
                                     ent.center_y > line_y_reg) begin
                            total_out_reg <= total_out_reg + 16'd1;
                        end
                    end
                    idx_reg <= idx_reg + CW'(1);
                    if (last_entry) begin
                        live_reg  <= tracked_reg[idx] ? kept_reg + CW'(1) : kept_reg;
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_ARD;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_id_reg   <= id_reg;
            m_new_reg  <= new_reg;
            m_drop_reg <= drop_reg;
            m_in_reg   <= total_in_reg;
            m_out_reg  <= total_out_reg;
            m_live_reg <= 5'(live_reg);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_live_reg, m_out_reg, m_in_reg, m_id_reg};
    assign m_tuser  = {m_drop_reg, m_new_reg};

`ifndef SYNTH
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CW'(MAX_OBJECTS))
        else $error("live count above table depth");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after accept");
    a_new_xor_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("new and dropped both set");
    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_reg <= idx_reg)
        else $error("compaction index ahead of scan");
`endif

endmodule

>>> rtl/core/ptrk_sq.sv
// ----------------------------------------------------------------------------
// ptrk_sq
// Shared registered squarer for distances and threshold squares.
// ----------------------------------------------------------------------------
module ptrk_sq (
    input  logic               aclk,
    input  logic signed [16:0] operand,
    output logic [32:0]        square_reg
);
    logic signed [33:0] product;

    assign product = operand * operand;

    always_ff @(posedge aclk) begin
        square_reg <= product[32:0];
    end
endmodule

>>> rtl/core/ptrk_ram.sv
// ----------------------------------------------------------------------------
// ptrk_ram
// Entry table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptrk_ram #(
    parameter int DEPTH = ptrk_pkg::MAX_OBJECTS_DEF
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  ptrk_pkg::entry_t              wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output ptrk_pkg::entry_t              rdata_reg
);
    ptrk_pkg::entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end
endmodule
